// ===== src/hcbd_pkg.sv =====
// hcbd_pkg: shared widths, register indexes, error codes and character
// constants for the chunked body decoder; no dependencies
`timescale 1ns / 1ps

package hcbd_pkg;

    // width of chunk size, bytes left and body total counters
    localparam int LENGTH_BITS = 32;
    // size accumulator after one more hex digit
    localparam int ACC_W = LENGTH_BITS + 4;
    // common width for size and total compares against the body limit
    localparam int CMP_W = (ACC_W > 33) ? ACC_W : 33;

    localparam int BODY_LIM_W = 32;
    localparam int TRL_LIM_W  = 16;
    localparam int CNT16_W    = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRAILER = 1'd1;

    // configuration reset values
    localparam logic [BODY_LIM_W-1:0] MAX_BODY_RESET    = 32'd1048576;
    localparam logic [TRL_LIM_W-1:0]  MAX_TRAILER_RESET = 16'd8192;

    // error codes
    typedef logic [2:0] err_code_t;
    localparam err_code_t ERR_NONE        = 3'd0;
    localparam err_code_t ERR_BAD_DIGIT   = 3'd1;
    localparam err_code_t ERR_TOO_LARGE   = 3'd2;
    localparam err_code_t ERR_BAD_TERM    = 3'd3;
    localparam err_code_t ERR_NO_COLON    = 3'd4;
    localparam err_code_t ERR_TRAILER_BIG = 3'd5;

    // characters of the chunked syntax
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;

endpackage

// ===== src/hcbd_in_if.sv =====
// hcbd_in_if: raw byte channel of the chunked body decoder
// depends on nothing
`timescale 1ns / 1ps

interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_of_message;

    modport source (output valid, output in_byte, output first_of_message, input ready);
    modport sink   (input valid, input in_byte, input first_of_message, output ready);
endinterface

// ===== src/hcbd_out_if.sv =====
// hcbd_out_if: decoded result channel of the chunked body decoder
// depends on hcbd_pkg for the error code type
`timescale 1ns / 1ps

interface hcbd_out_if;
    logic               valid;
    logic               ready;
    logic               body_valid;
    logic [7:0]         body_byte;
    logic               message_done;
    hcbd_pkg::err_code_t error_code;

    modport source (output valid, output body_valid, output body_byte, output message_done,
                    output error_code, input ready);
    modport sink   (input valid, input body_valid, input body_byte, input message_done,
                    input error_code, output ready);
endinterface

// ===== src/http_chunked_body_decoder.sv =====
// http_chunked_body_decoder: byte-wide decoder for chunked message bodies
// depends on hcbd_pkg, hcbd_in_if and hcbd_out_if
`timescale 1ns / 1ps

// Usage
//   raw carries one byte of the chunked body per word, with first_of_message
//   set on the first byte of each new body. decoded carries exactly one word
//   per raw word: body_valid/body_byte for payload, message_done on the LF of
//   the blank line that ends the trailers, and error_code, which holds the
//   first error of the message on every word until the next message starts.
//   Limits are written through cfg_we/cfg_index/cfg_data while idle.
// Timing
//   Each byte is held in an input register, then the decode step (one hex
//   shift, one 36-bit add and compare against the body limit) updates the
//   parse state and fills the result register, which drives decoded.
//   Throughput is one byte per cycle while decoded is taken.
// Reset and stall
//   rst_n clears the parse state to the start of a size line, restores the
//   default limits and empties both registers. When decoded is not taken,
//   the result register holds, the input register holds its byte, and raw
//   drops ready once both are full; nothing is lost or repeated.
module http_chunked_body_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    hcbd_in_if.sink                             raw,
    hcbd_out_if.source                          decoded,
    input  logic                                cfg_we,
    input  logic [hcbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hcbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // parse phases
    localparam logic [3:0] PH_SIZE    = 4'd0;
    localparam logic [3:0] PH_SIZE_LF = 4'd1;
    localparam logic [3:0] PH_DATA    = 4'd2;
    localparam logic [3:0] PH_DATA_CR = 4'd3;
    localparam logic [3:0] PH_DATA_LF = 4'd4;
    localparam logic [3:0] PH_TRL     = 4'd5;
    localparam logic [3:0] PH_TRL_LF  = 4'd6;
    localparam logic [3:0] PH_DONE    = 4'd7;
    localparam logic [3:0] PH_ERR     = 4'd8;

    localparam int LB  = hcbd_pkg::LENGTH_BITS;
    localparam int CW  = hcbd_pkg::CMP_W;
    localparam int C16 = hcbd_pkg::CNT16_W;

    // saturating 16-bit add
    function automatic logic [C16-1:0] sat_add16(input logic [C16-1:0] a,
                                                 input logic [C16-1:0] b);
        logic [C16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[C16] ? {C16{1'b1}} : s[C16-1:0];
    endfunction

    // hex digit decode, bit 4 flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    // configuration registers
    logic [hcbd_pkg::BODY_LIM_W-1:0] max_body_reg;
    logic [hcbd_pkg::TRL_LIM_W-1:0]  max_trailer_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_first_reg;

    // parse state
    logic [3:0]                phase_reg, phase_next;
    logic [LB-1:0]             acc_reg, acc_next;
    logic [LB-1:0]             left_reg, left_next;
    logic [LB-1:0]             total_reg, total_next;
    logic [C16-1:0]            trl_bytes_reg, trl_bytes_next;
    logic [C16-1:0]            line_len_reg, line_len_next;
    logic                      colon_reg, colon_next;
    logic                      ext_reg, ext_next;
    hcbd_pkg::err_code_t       err_reg, err_next;

    // result register
    logic                      out_valid_reg;
    logic                      out_body_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      out_done_reg;
    hcbd_pkg::err_code_t       out_err_reg;

    logic res_valid;
    logic res_done;
    logic advance;

    // pipeline flow control
    assign advance   = !out_valid_reg || decoded.ready;
    assign raw.ready = !s1_valid_reg || advance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg    <= hcbd_pkg::MAX_BODY_RESET;
            max_trailer_reg <= hcbd_pkg::MAX_TRAILER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hcbd_pkg::REG_MAX_BODY:
                    max_body_reg <= cfg_data[hcbd_pkg::BODY_LIM_W-1:0];
                hcbd_pkg::REG_MAX_TRAILER:
                    max_trailer_reg <= cfg_data[hcbd_pkg::TRL_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (raw.ready)
        begin
            s1_valid_reg <= raw.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.valid && raw.ready)
        begin
            s1_byte_reg  <= raw.in_byte;
            s1_first_reg <= raw.first_of_message;
        end
    end

    // one decode step
    always_comb
    begin
        logic [7:0]    b;
        logic [4:0]    hd;
        logic [CW-1:0] acc_shift;
        logic [CW-1:0] sum_total;
        logic [CW-1:0] max_wide;
        logic [LB-1:0] left_dec;
        logic [C16-1:0] ll_p1;
        logic [C16-1:0] ll_p2;

        b = s1_byte_reg;

        // restart on first byte of a message
        if (s1_first_reg)
        begin
            phase_next     = PH_SIZE;
            acc_next       = '0;
            left_next      = '0;
            total_next     = '0;
            trl_bytes_next = '0;
            line_len_next  = '0;
            colon_next     = 1'b0;
            ext_next       = 1'b0;
            err_next       = hcbd_pkg::ERR_NONE;
        end
        else
        begin
            phase_next     = phase_reg;
            acc_next       = acc_reg;
            left_next      = left_reg;
            total_next     = total_reg;
            trl_bytes_next = trl_bytes_reg;
            line_len_next  = line_len_reg;
            colon_next     = colon_reg;
            ext_next       = ext_reg;
            err_next       = err_reg;
        end

        hd        = hex_digit(b);
        acc_shift = CW'({acc_next, hd[3:0]});
        max_wide  = CW'(max_body_reg);
        sum_total = CW'(total_next) + CW'(acc_next);
        left_dec  = left_next - LB'(1);
        ll_p1     = sat_add16(line_len_next, C16'(1));
        ll_p2     = sat_add16(line_len_next, C16'(2));

        res_valid = 1'b0;
        res_done  = 1'b0;

        unique case (phase_next)
            PH_SIZE:
            begin
                if (ext_next)
                begin
                    if (b == hcbd_pkg::CH_CR)
                        phase_next = PH_SIZE_LF;
                end
                else if (b == hcbd_pkg::CH_SEMI)
                begin
                    ext_next = 1'b1;
                end
                else if (b == hcbd_pkg::CH_CR)
                begin
                    phase_next = PH_SIZE_LF;
                end
                else if (!hd[4])
                begin
                    phase_next = PH_ERR;
                    err_next   = hcbd_pkg::ERR_BAD_DIGIT;
                end
                else if (acc_shift > max_wide || acc_shift[CW-1:LB] != '0)
                begin
                    phase_next = PH_ERR;
                    err_next   = hcbd_pkg::ERR_TOO_LARGE;
                end
                else
                begin
                    acc_next      = acc_shift[LB-1:0];
                    line_len_next = ll_p1;
                end
            end

            PH_SIZE_LF:
            begin
                if (b == hcbd_pkg::CH_LF)
                begin
                    // end of size line
                    if (line_len_next == '0)
                    begin
                        phase_next = PH_ERR;
                        err_next   = hcbd_pkg::ERR_BAD_DIGIT;
                    end
                    else if (acc_next == '0)
                    begin
                        phase_next     = PH_TRL;
                        line_len_next  = '0;
                        colon_next     = 1'b0;
                        trl_bytes_next = '0;
                    end
                    else if (sum_total > max_wide)
                    begin
                        phase_next = PH_ERR;
                        err_next   = hcbd_pkg::ERR_TOO_LARGE;
                    end
                    else
                    begin
                        total_next = sum_total[LB-1:0];
                        left_next  = acc_next;
                        phase_next = PH_DATA;
                    end
                end
                else if (ext_next)
                begin
                    // stray cr inside an extension is ignored
                    phase_next = (b == hcbd_pkg::CH_CR) ? PH_SIZE_LF : PH_SIZE;
                end
                else
                begin
                    phase_next = PH_ERR;
                    err_next   = hcbd_pkg::ERR_BAD_DIGIT;
                end
            end

            PH_DATA:
            begin
                res_valid = 1'b1;
                left_next = left_dec;
                if (left_dec == '0)
                    phase_next = PH_DATA_CR;
            end

            PH_DATA_CR:
            begin
                if (b == hcbd_pkg::CH_CR)
                begin
                    phase_next = PH_DATA_LF;
                end
                else
                begin
                    phase_next = PH_ERR;
                    err_next   = hcbd_pkg::ERR_BAD_TERM;
                end
            end

            PH_DATA_LF:
            begin
                if (b == hcbd_pkg::CH_LF)
                begin
                    phase_next    = PH_SIZE;
                    acc_next      = '0;
                    line_len_next = '0;
                    ext_next      = 1'b0;
                end
                else
                begin
                    phase_next = PH_ERR;
                    err_next   = hcbd_pkg::ERR_BAD_TERM;
                end
            end

            PH_TRL:
            begin
                if (b == hcbd_pkg::CH_CR)
                begin
                    phase_next = PH_TRL_LF;
                end
                else
                begin
                    line_len_next = ll_p1;
                    if (b == hcbd_pkg::CH_COLON)
                        colon_next = 1'b1;
                end
            end

            PH_TRL_LF:
            begin
                if (b == hcbd_pkg::CH_LF)
                begin
                    // end of trailer line
                    if (trl_bytes_next > max_trailer_reg)
                    begin
                        phase_next = PH_ERR;
                        err_next   = hcbd_pkg::ERR_TRAILER_BIG;
                    end
                    else if (line_len_next == '0)
                    begin
                        phase_next = PH_DONE;
                        res_done   = 1'b1;
                    end
                    else if (!colon_next)
                    begin
                        phase_next = PH_ERR;
                        err_next   = hcbd_pkg::ERR_NO_COLON;
                    end
                    else
                    begin
                        trl_bytes_next = sat_add16(trl_bytes_next, ll_p2);
                        line_len_next  = '0;
                        colon_next     = 1'b0;
                        phase_next     = PH_TRL;
                    end
                end
                else if (b == hcbd_pkg::CH_CR)
                begin
                    // the earlier cr counts as content, this one may end the line
                    line_len_next = ll_p1;
                    phase_next    = PH_TRL_LF;
                end
                else
                begin
                    line_len_next = ll_p2;
                    phase_next    = PH_TRL;
                    if (b == hcbd_pkg::CH_COLON)
                        colon_next = 1'b1;
                end
            end

            default: ;
        endcase
    end

    // parse state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            acc_reg       <= '0;
            left_reg      <= '0;
            total_reg     <= '0;
            trl_bytes_reg <= '0;
            line_len_reg  <= '0;
            colon_reg     <= 1'b0;
            ext_reg       <= 1'b0;
            err_reg       <= hcbd_pkg::ERR_NONE;
        end
        else if (advance && s1_valid_reg)
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            left_reg      <= left_next;
            total_reg     <= total_next;
            trl_bytes_reg <= trl_bytes_next;
            line_len_reg  <= line_len_next;
            colon_reg     <= colon_next;
            ext_reg       <= ext_next;
            err_reg       <= err_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_body_valid_reg <= res_valid;
            out_byte_reg       <= res_valid ? s1_byte_reg : 8'd0;
            out_done_reg       <= res_done;
            out_err_reg        <= err_next;
        end
    end

    assign decoded.valid        = out_valid_reg;
    assign decoded.body_valid   = out_body_valid_reg;
    assign decoded.body_byte    = out_byte_reg;
    assign decoded.message_done = out_done_reg;
    assign decoded.error_code   = out_err_reg;

    // checks
    a_body_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_body_valid_reg |-> out_err_reg == hcbd_pkg::ERR_NONE)
        else $error("payload word carries an error code");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> !out_body_valid_reg
                                          && out_err_reg == hcbd_pkg::ERR_NONE)
        else $error("message end word carries payload or error");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !raw.ready |-> s1_valid_reg && out_valid_reg && !decoded.ready)
        else $error("raw stalled without a pending result");

    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERR |-> err_reg != hcbd_pkg::ERR_NONE)
        else $error("error phase without an error code");

    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> left_reg != '0)
        else $error("data phase with no bytes left");

endmodule
